// ===== hw/rtl/rau_pkg.sv =====
// Shared types and codes of the rational arithmetic unit.
`default_nettype none
package rau_pkg;

    // Operation codes carried in tuser
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_MUL    = 2'd1;
    localparam logic [1:0] OP_CMP    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Compare outcome codes
    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    // Kind of one sequencer step
    typedef enum logic [1:0] {
        K_GCD,
        K_DIV,
        K_MUL,
        K_END
    } t_kind;

    // Destination of a step result
    typedef enum logic [3:0] {
        D_G1,
        D_G2,
        D_QA,
        D_QB,
        D_QC,
        D_QD,
        D_ACC,
        D_ACC_ADD,
        D_DEN,
        D_ORDER
    } t_dst;

    // One decoded step: what to run, on what, and where the answer goes
    typedef struct packed {
        t_kind              kind;
        logic signed [32:0] x;
        logic signed [32:0] y;
        t_dst               dst;
    } t_uop;

endpackage
`default_nettype wire

// ===== hw/rtl/rau_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module rau_div
    import rau_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quo,
    output logic [31:0]      o_rem
);

    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_done;
    logic [32:0] shifted;
    logic        fits;

    // Trial subtraction of the divisor from the shifted remainder
    always_comb begin
        shifted = {r_rem[31:0], r_quo[31]};
        fits    = shifted >= {1'b0, r_dvs};
    end

    // Control: iteration count and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= 6'd32;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 6'd1;
                r_done <= (r_cnt == 6'd1);
            end
        end
    end

    // Datapath: load operands, then shift in one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? (shifted - {1'b0, r_dvs}) : shifted;
            r_quo <= {r_quo[30:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[31:0];

endmodule
`default_nettype wire

// ===== hw/rtl/rau_mul.sv =====
// Registered 33 by 33 signed multiplier; the product is ready in the cycle after start.
`default_nettype none
module rau_mul
    import rau_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [32:0] i_x,
    input  wire logic signed [32:0] i_y,
    output logic                    o_done,
    output logic signed [63:0]      o_prod
);

    logic signed [65:0] full;
    logic               r_done;
    logic signed [63:0] r_prod;

    assign full = i_x * i_y;

    // Hold done for one cycle after a start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // Capture the low 64 bits of the 66-bit product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= full[63:0];
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// Top level: sequencer and operand registers of the rational arithmetic unit.
//
// Usage: one input beat on s_axis carries two rationals and an operation in
// tuser (add, multiply, compare). One result beat on m_axis follows.
// s_axis_tready is high only while the block is idle; one item is worked on
// at a time. The sequencer drives a shared iterative divider (Euclid steps
// and exact quotients) and a registered multiplier.
// Steps from the accepting edge to m_axis_tvalid: compare runs products
// only; add 1 gcd plus 2 divisions plus 3 products, multiply 2 gcds plus
// 4 divisions plus 2 products. A gcd runs the divider once per Euclid step,
// so the time of add and multiply depends on the operands. The sequencer
// passes through its result and idle states before the next beat is taken.
// The result is held in an output register until m_axis_tready takes it; a
// stalled receiver only delays the return to idle.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops
// any item in flight; no result is pending after reset.
`default_nettype none
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // a_num[31:0], a_den[62:32], b_num[94:63], b_den[125:95], zero[127:126]
    input  wire logic [127:0] s_axis_tdata,
    // operation[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // res_num[31:0], res_den[62:32], order[64:63], overflow[65], zero[71:66]
    output logic [71:0]       m_axis_tdata
);

    localparam int W = WORD_BITS;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_ISSUE    = 7'b0000010,
        S_GCD      = 7'b0000100,
        S_GCD_WAIT = 7'b0001000,
        S_DIV_WAIT = 7'b0010000,
        S_MUL_WAIT = 7'b0100000,
        S_OUT      = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [3:0]  r_step;
    logic [1:0]  r_op;
    logic signed [31:0] r_an, r_bn;
    logic [30:0] r_ad, r_bd;
    logic [31:0] r_am, r_bm;
    logic        r_neg;
    logic [30:0] r_g1, r_g2;
    logic [31:0] r_qa, r_qb;
    logic [30:0] r_qc, r_qd;
    logic signed [63:0] r_acc;
    logic [63:0] r_den;
    logic [1:0]  r_order;
    logic [31:0] r_gx, r_gy;
    logic [31:0] r_out_num;
    logic [30:0] r_out_den;
    logic [1:0]  r_out_order;
    logic        r_out_ovf;

    t_uop        uop;
    logic        div_start, div_done;
    logic [31:0] div_a, div_b, div_quo, div_rem;
    logic        mul_start, mul_done;
    logic signed [63:0] mul_prod;
    logic        wb_en;
    logic [63:0] wb_val;
    logic        accept;
    logic [30:0] in_ad, in_bd;
    logic signed [31:0] in_an, in_bn;
    logic signed [63:0] fin_num;
    logic signed [W-1:0] fin_low;
    logic [63:0] fin_den_low;
    logic        fin_ovf;
    logic [31:0] fin_res_num;
    logic [30:0] fin_res_den;

    // Unpack the input beat; a zero denominator counts as one
    always_comb begin
        in_an  = s_axis_tdata[31:0];
        in_bn  = s_axis_tdata[94:63];
        in_ad  = (s_axis_tdata[62:32] == '0) ? 31'd1 : s_axis_tdata[62:32];
        in_bd  = (s_axis_tdata[125:95] == '0) ? 31'd1 : s_axis_tdata[125:95];
        accept = s_axis_tvalid && s_axis_tready;
    end

    // Decode the current step of the running operation
    always_comb begin
        uop = '{kind: K_END, x: '0, y: '0, dst: D_ACC};
        case (r_op)
            OP_ADD: begin
                case (r_step)
                    4'd0: uop = '{K_GCD, 33'({1'b0, r_ad}), 33'({1'b0, r_bd}), D_G1};
                    4'd1: uop = '{K_DIV, 33'({1'b0, r_bd}), 33'({1'b0, r_g1}), D_QB};
                    4'd2: uop = '{K_DIV, 33'({1'b0, r_ad}), 33'({1'b0, r_g1}), D_QA};
                    4'd3: uop = '{K_MUL, 33'(r_an), {1'b0, r_qb}, D_ACC};
                    4'd4: uop = '{K_MUL, 33'(r_bn), {1'b0, r_qa}, D_ACC_ADD};
                    4'd5: uop = '{K_MUL, {1'b0, r_qa}, 33'({1'b0, r_bd}), D_DEN};
                    default: ;
                endcase
            end
            OP_MUL: begin
                case (r_step)
                    4'd0: uop = '{K_GCD, 33'({1'b0, r_ad}), {1'b0, r_bm}, D_G1};
                    4'd1: uop = '{K_GCD, 33'({1'b0, r_bd}), {1'b0, r_am}, D_G2};
                    4'd2: uop = '{K_DIV, {1'b0, r_am}, 33'({1'b0, r_g2}), D_QA};
                    4'd3: uop = '{K_DIV, {1'b0, r_bm}, 33'({1'b0, r_g1}), D_QB};
                    4'd4: uop = '{K_DIV, 33'({1'b0, r_ad}), 33'({1'b0, r_g1}), D_QC};
                    4'd5: uop = '{K_DIV, 33'({1'b0, r_bd}), 33'({1'b0, r_g2}), D_QD};
                    4'd6: uop = '{K_MUL, {1'b0, r_qa}, {1'b0, r_qb}, D_ACC};
                    4'd7: uop = '{K_MUL, 33'({1'b0, r_qc}), 33'({1'b0, r_qd}), D_DEN};
                    default: ;
                endcase
            end
            OP_CMP: begin
                case (r_step)
                    4'd0: uop = '{K_MUL, 33'(r_an), 33'({1'b0, r_bd}), D_ACC};
                    4'd1: uop = '{K_MUL, 33'(r_bn), 33'({1'b0, r_ad}), D_ORDER};
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Shared units
    assign div_a = (r_state == S_GCD) ? r_gx : uop.x[31:0];
    assign div_b = (r_state == S_GCD) ? r_gy : uop.y[31:0];

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    rau_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (uop.x),
        .i_y     (uop.y),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Fit the exact result to the signed word
    always_comb begin
        fin_num     = (r_op == OP_MUL && r_neg) ? -r_acc : r_acc;
        fin_low     = fin_num[W-1:0];
        fin_den_low = 64'(r_den[W-1:0]);
        fin_ovf     = (fin_num[63:W-1] != {(65-W){fin_num[W-1]}})
                   || (r_den[63:W-1] != '0);
        fin_res_num = 32'(fin_low);
        fin_res_den = fin_den_low[30:0];
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        mul_start = 1'b0;
        wb_en     = 1'b0;
        wb_val    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                unique case (uop.kind)
                    K_GCD: n_state = S_GCD;
                    K_DIV: begin
                        div_start = 1'b1;
                        n_state   = S_DIV_WAIT;
                    end
                    K_MUL: begin
                        mul_start = 1'b1;
                        n_state   = S_MUL_WAIT;
                    end
                    K_END: n_state = S_OUT;
                    default: n_state = S_OUT;
                endcase
            end
            S_GCD: begin
                if (r_gy == '0) begin
                    wb_en   = 1'b1;
                    wb_val  = 64'(r_gx);
                    n_state = S_ISSUE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT: begin
                if (div_done) begin
                    n_state = S_GCD;
                end
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    wb_en   = 1'b1;
                    wb_val  = 64'(div_quo);
                    n_state = S_ISSUE;
                end
            end
            S_MUL_WAIT: begin
                if (mul_done) begin
                    wb_en   = 1'b1;
                    wb_val  = mul_prod;
                    n_state = S_ISSUE;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_step <= '0;
            end else if (wb_en) begin
                r_step <= r_step + 4'd1;
            end
        end
    end

    // Operand capture, Euclid registers, write-back and result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= s_axis_tuser;
            r_an    <= in_an;
            r_bn    <= in_bn;
            r_ad    <= in_ad;
            r_bd    <= in_bd;
            r_am    <= in_an[31] ? (32'd0 - in_an) : in_an;
            r_bm    <= in_bn[31] ? (32'd0 - in_bn) : in_bn;
            r_neg   <= in_an[31] ^ in_bn[31];
            r_acc   <= '0;
            r_den   <= '0;
            r_order <= ORD_LESS;
        end
        if (r_state == S_ISSUE && uop.kind == K_GCD) begin
            r_gx <= uop.x[31:0];
            r_gy <= uop.y[31:0];
        end else if (r_state == S_GCD_WAIT && div_done) begin
            r_gx <= r_gy;
            r_gy <= div_rem;
        end
        if (wb_en) begin
            case (uop.dst)
                D_G1:      r_g1 <= wb_val[30:0];
                D_G2:      r_g2 <= wb_val[30:0];
                D_QA:      r_qa <= wb_val[31:0];
                D_QB:      r_qb <= wb_val[31:0];
                D_QC:      r_qc <= wb_val[30:0];
                D_QD:      r_qd <= wb_val[30:0];
                D_ACC:     r_acc <= wb_val;
                D_ACC_ADD: r_acc <= r_acc + wb_val;
                D_DEN:     r_den <= wb_val;
                D_ORDER: begin
                    if (r_acc < $signed(wb_val)) begin
                        r_order <= ORD_LESS;
                    end else if (r_acc == $signed(wb_val)) begin
                        r_order <= ORD_EQUAL;
                    end else begin
                        r_order <= ORD_GREATER;
                    end
                end
                default: ;
            endcase
        end
        if (r_state == S_ISSUE && uop.kind == K_END) begin
            r_out_num   <= '0;
            r_out_den   <= '0;
            r_out_order <= ORD_LESS;
            r_out_ovf   <= 1'b0;
            case (r_op)
                OP_ADD, OP_MUL: begin
                    r_out_num <= fin_res_num;
                    r_out_den <= fin_res_den;
                    r_out_ovf <= fin_ovf;
                end
                OP_CMP: r_out_order <= r_order;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {6'b0, r_out_ovf, r_out_order, r_out_den, r_out_num};

endmodule
`default_nettype wire
